FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the serial angle command responder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/sacr_pkg.sv
// ----------------------------------------------------------------------------
// Serial angle command responder package
// Byte codes, channel widths and the reply descriptor shared by all modules.
// ----------------------------------------------------------------------------
package sacr_pkg;

    // Byte codes of the command protocol.
    localparam logic [7:0] LF_CODE   = 8'h0A;
    localparam logic [7:0] CMD_ANGLE = 8'h01;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] ACK_ANGLE = 8'h03;
    localparam logic [7:0] ACK_WRITE = 8'h04;
    localparam logic [7:0] CMD_PITCH = 8'h05;
    localparam logic [7:0] CMD_ROLL  = 8'h06;
    localparam logic [7:0] ACK_PITCH = 8'h07;
    localparam logic [7:0] ACK_ROLL  = 8'h08;
    localparam logic [7:0] ERR_CODE  = 8'h19;

    // Reply lengths in bytes.
    localparam int REPLY_BYTES_MAX = 6;
    localparam int REPLY_CNT_W     = 3;
    localparam logic [REPLY_CNT_W-1:0] REPLY_LONG_LEN  = 3'd6;
    localparam logic [REPLY_CNT_W-1:0] REPLY_SHORT_LEN = 3'd2;

    // Channel widths.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    // One decoded reply: bytes in sending order, lowest byte first.
    typedef struct packed {
        logic [8*REPLY_BYTES_MAX-1:0] bytes;
        logic [REPLY_CNT_W-1:0]       len;
        logic [31:0]                  reference_word;
    } reply_desc_t;

endpackage

FILE: sv/sacr_frame_decoder.sv
// ----------------------------------------------------------------------------
// Frame decoder
// Writes received bytes into the frame store, decodes a frame on a line feed
// and registers the reply descriptor for the serializer.
// ----------------------------------------------------------------------------
module sacr_frame_decoder #(
    parameter int FRAME_BYTES = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           rx_byte,
    input  logic [31:0]          angle_bits,
    input  logic [31:0]          pitch_bits,
    input  logic [31:0]          roll_bits,
    input  logic                 desc_load,
    output logic                 desc_valid,
    output sacr_pkg::reply_desc_t desc
);
    import sacr_pkg::*;

    localparam int WPW  = $clog2(FRAME_BYTES + 1);
    localparam int IDXW = $clog2(FRAME_BYTES);

    logic [7:0]     store_reg [FRAME_BYTES];
    logic [WPW-1:0] wp_reg, wp_next;
    logic [31:0]    reference_reg, reference_next;
    logic           desc_valid_reg, desc_valid_next;
    reply_desc_t    desc_reg, desc_next;

    logic [7:0]     view [6];
    logic           room;
    logic           is_lf;
    logic           lf1, lf5;
    logic [7:0]     cmd;

    // Frame as it stands once the current item has been written.
    assign room  = (wp_reg < WPW'(FRAME_BYTES));
    assign is_lf = (rx_byte == LF_CODE);

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            view[i] = (wp_reg == WPW'(i)) ? rx_byte : store_reg[i];
        end
    end

    assign cmd = view[0];
    assign lf1 = (view[1] == LF_CODE);
    assign lf5 = (view[5] == LF_CODE);

    // Decode and next-state logic.
    always_comb begin
        wp_next         = wp_reg;
        reference_next  = reference_reg;
        desc_valid_next = desc_valid_reg && !desc_load;
        desc_next       = desc_reg;
        if (in_accept) begin
            if (room) begin
                wp_next = wp_reg + WPW'(1);
            end
            if (is_lf) begin
                wp_next         = '0;
                desc_valid_next = 1'b1;
                desc_next.len   = REPLY_SHORT_LEN;
                desc_next.bytes = {32'h0, LF_CODE, ERR_CODE};
                case (cmd)
                    CMD_ANGLE: begin
                        if (lf1) begin
                            desc_next.len   = REPLY_LONG_LEN;
                            desc_next.bytes = {LF_CODE, angle_bits, ACK_ANGLE};
                        end
                    end
                    CMD_PITCH: begin
                        if (lf1) begin
                            desc_next.len   = REPLY_LONG_LEN;
                            desc_next.bytes = {LF_CODE, pitch_bits, ACK_PITCH};
                        end
                    end
                    CMD_ROLL: begin
                        if (lf1) begin
                            desc_next.len   = REPLY_LONG_LEN;
                            desc_next.bytes = {LF_CODE, roll_bits, ACK_ROLL};
                        end
                    end
                    CMD_WRITE: begin
                        if (lf5) begin
                            reference_next  = {view[4], view[3], view[2], view[1]};
                            desc_next.bytes = {32'h0, LF_CODE, ACK_WRITE};
                        end
                    end
                    default: begin
                    end
                endcase
                desc_next.reference_word = reference_next;
            end
        end
    end

    // Frame store, write position, reference word and descriptor valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                store_reg[i] <= '0;
            end
            wp_reg         <= '0;
            reference_reg  <= '0;
            desc_valid_reg <= 1'b0;
        end else begin
            if (in_accept && room) begin
                store_reg[wp_reg[IDXW-1:0]] <= rx_byte;
            end
            wp_reg         <= wp_next;
            reference_reg  <= reference_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    // Descriptor payload needs no reset.
    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

FILE: sv/sacr_reply_serializer.sv
// ----------------------------------------------------------------------------
// Reply serializer
// Loads a reply descriptor and sends its bytes one item per cycle while m_tready
// is high on the result channel, marking the closing line feed.
// ----------------------------------------------------------------------------
module sacr_reply_serializer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          desc_valid,
    input  sacr_pkg::reply_desc_t         desc,
    output logic                          desc_load,
    output logic                          busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sacr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import sacr_pkg::*;

    logic                         busy_reg, busy_next;
    logic [8*REPLY_BYTES_MAX-1:0] shift_reg, shift_next;
    logic [REPLY_CNT_W-1:0]       count_reg, count_next;
    logic [31:0]                  ref_word_reg, ref_word_next;
    logic                         out_fire;
    logic                         last_fire;

    assign out_fire  = busy_reg && m_tready;
    assign last_fire = out_fire && (count_reg == REPLY_CNT_W'(1));

    // A new reply enters when the current one is done or finishing.
    assign desc_load = desc_valid && (!busy_reg || last_fire);

    always_comb begin
        busy_next     = busy_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        ref_word_next = ref_word_reg;
        if (out_fire) begin
            shift_next = shift_reg >> 8;
            count_next = count_reg - REPLY_CNT_W'(1);
            if (last_fire) begin
                busy_next = 1'b0;
            end
        end
        if (desc_load) begin
            busy_next     = 1'b1;
            shift_next    = desc.bytes;
            count_next    = desc.len;
            ref_word_next = desc.reference_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        count_reg    <= count_next;
        ref_word_reg <= ref_word_next;
    end

    assign busy     = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tdata  = {ref_word_reg, shift_reg[7:0]};
    assign m_tlast  = (count_reg == REPLY_CNT_W'(1));

endmodule

FILE: sv/serial_angle_command_responder.sv
// ----------------------------------------------------------------------------
// Serial angle command responder
// Collects received bytes into a frame and answers each line-feed-closed
// frame with a two or six byte reply.
// ----------------------------------------------------------------------------
// A line feed accepted while the serializer is idle is registered in the
//   descriptor register, then loaded into the serializer, which raises m_tvalid
//   with its first reply byte.
// Throughput: one input item per cycle while no reply waits behind a busy
//   serializer; the serializer sends one reply byte per cycle while m_tready is
//   high, so a frame occupies it until its two or six reply bytes are sent, and
//   s_tready drops while a decoded reply waits for it.
// Reset: aresetn low clears the frame store, write position, reference word
//   and both valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_angle_command_responder #(
    parameter int FRAME_BYTES = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: rx_byte[7:0], angle_bits[39:8], pitch_bits[71:40], roll_bits[103:72]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sacr_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: tx_byte[7:0], reference_angle[39:8]; m_tlast: last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sacr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import sacr_pkg::*;

    logic        in_accept;
    logic        desc_valid;
    logic        desc_load;
    logic        ser_busy;
    reply_desc_t desc;
    logic [7:0]  rx_byte;

    // The descriptor register is free, or drains into an idle serializer.
    assign s_tready  = !desc_valid || !ser_busy;
    assign in_accept = s_tvalid && s_tready;
    assign rx_byte   = s_tdata[7:0];

    sacr_frame_decoder #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .rx_byte    (rx_byte),
        .angle_bits (s_tdata[39:8]),
        .pitch_bits (s_tdata[71:40]),
        .roll_bits  (s_tdata[103:72]),
        .desc_load  (desc_load),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    sacr_reply_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_load  (desc_load),
        .busy       (ser_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // A pending reply never waits on an idle serializer.
    `ASSERT_ALWAYS(a_idle_loads, aclk, aresetn, !(desc_valid && !ser_busy) || desc_load, "pending reply not loaded into idle serializer")

    // A line feed item always produces a pending reply.
    `ASSERT_NEXT(a_lf_gives_reply, aclk, aresetn, in_accept && (rx_byte == LF_CODE), desc_valid, "line feed item produced no reply")

    // The closing byte taken with nothing queued leaves the channel empty.
    `ASSERT_NEXT(a_reply_ends, aclk, aresetn, m_tvalid && m_tready && m_tlast && !desc_load, !m_tvalid, "result channel still valid after closing byte")

endmodule

FILE: dv/serial_angle_command_responder_test.sv
// ----------------------------------------------------------------------------
// Serial angle command responder testbench
// Streams received bytes into the responder and checks every reply item.
// A short directed table covers each command, the stale-byte write, the
// overlong frame and the reset state. Random frames follow, mostly well
// formed, with noise mixed in. An in-bench model of the frame store predicts
// each untyped reply, and both channels stall at random in two of three phases.
// ----------------------------------------------------------------------------
module serial_angle_command_responder_test;

    import sacr_pkg::*;

    localparam int FRAME_LEN     = 6;
    localparam int RANDOM_ITEMS  = 396;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;

    // One input item, packed as it travels on s_tdata (received byte lowest).
    typedef struct packed {
        logic [31:0] roll;
        logic [31:0] pitch;
        logic [31:0] angle;
        logic [7:0]  rx;
    } rx_item_t;

    // One reply item as seen on the result channel.
    typedef struct packed {
        logic [7:0]  tx;
        logic        last;
        logic [31:0] refw;
    } reply_byte_t;

    // All reply items caused by one input item.
    typedef struct {
        int          count;
        reply_byte_t bytes [REPLY_BYTES_MAX];
    } reply_t;

    // A stimulus row; literal rows carry their short reply typed in.
    typedef struct {
        rx_item_t    it;
        bit          literal;
        logic [7:0]  code;
        logic [31:0] refw;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    // Shadow copy of the responder state.
    logic [7:0]  rx_frame [FRAME_LEN] = '{default: 8'h00};
    int          frame_wr_pos = 0;
    logic [31:0] ref_angle    = 32'h0;

    reply_byte_t reply_q [$];
    stim_row_t   pending_rows [$];
    stim_row_t   directed_rows [24];
    logic [7:0]  read_cmds [3] = '{CMD_ANGLE, CMD_PITCH, CMD_ROLL};

    int tx_idle_pct     = 13;
    int rx_idle_pct     = 62;
    int items_sent      = 0;
    int frames_sent     = 0;
    int replies_checked = 0;
    int literal_checked = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    serial_angle_command_responder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Two-item reply: a code, then the closing line feed.
    function automatic reply_t short_reply(logic [7:0] code, logic [31:0] refw);
        reply_t r;
        r.count    = 2;
        r.bytes[0] = '{code, 1'b0, refw};
        r.bytes[1] = '{LF_CODE, 1'b1, refw};
        return r;
    endfunction

    // Six-item reply: acknowledge, four data bytes low first, line feed.
    function automatic reply_t word_reply(logic [7:0] ack, logic [31:0] w);
        reply_t r;
        r.count    = 6;
        r.bytes[0] = '{ack, 1'b0, ref_angle};
        for (int k = 0; k < 4; k++) begin
            r.bytes[k + 1] = '{w[8*k +: 8], 1'b0, ref_angle};
        end
        r.bytes[5] = '{LF_CODE, 1'b1, ref_angle};
        return r;
    endfunction

    // Advance the shadow frame store by one received byte and decode on a line feed.
    function automatic reply_t frame_step(rx_item_t it);
        reply_t r;
        logic   lf_at_1;
        r.count = 0;
        if (frame_wr_pos < FRAME_LEN) begin
            rx_frame[frame_wr_pos] = it.rx;
            frame_wr_pos++;
        end
        if (it.rx != LF_CODE) begin
            return r;
        end
        frame_wr_pos = 0;
        lf_at_1 = (rx_frame[1] == LF_CODE);
        case (rx_frame[0])
            CMD_ANGLE: if (lf_at_1) r = word_reply(ACK_ANGLE, it.angle);
            CMD_PITCH: if (lf_at_1) r = word_reply(ACK_PITCH, it.pitch);
            CMD_ROLL:  if (lf_at_1) r = word_reply(ACK_ROLL, it.roll);
            CMD_WRITE: begin
                // The position-5 byte may be stale from an earlier, longer frame.
                if (rx_frame[5] == LF_CODE) begin
                    ref_angle = {rx_frame[4], rx_frame[3], rx_frame[2], rx_frame[1]};
                    r = short_reply(ACK_WRITE, ref_angle);
                end
            end
            default: ;
        endcase
        if (r.count == 0) begin
            r = short_reply(ERR_CODE, ref_angle);
        end
        return r;
    endfunction

    function automatic stim_row_t row_plain(logic [7:0] rx, logic [31:0] angle,
                                            logic [31:0] pitch, logic [31:0] roll);
        stim_row_t s;
        s.it      = '{roll: roll, pitch: pitch, angle: angle, rx: rx};
        s.literal = 1'b0;
        s.code    = 8'h00;
        s.refw    = 32'h0;
        return s;
    endfunction

    function automatic stim_row_t row_literal(logic [7:0] rx, logic [7:0] code,
                                              logic [31:0] refw);
        stim_row_t s;
        s         = row_plain(rx, 32'h0, 32'h0, 32'h0);
        s.literal = 1'b1;
        s.code    = code;
        s.refw    = refw;
        return s;
    endfunction

    // Sensor words lean toward the extremes now and then.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(11) == 0) begin
            return LF_CODE;
        end
        return 8'($urandom_range(255));
    endfunction

    // Offer one item, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_rx(stim_row_t r);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pending_rows.push_back(r);
        s_tdata  <= r.it;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (r.it.rx == LF_CODE) begin
            frames_sent++;
        end
    endtask

    // One random frame: mostly well-formed commands, some broken or noisy.
    task automatic send_random_frame();
        logic [7:0] body [$];
        case ($urandom_range(9))
            0, 1, 2: body.push_back(read_cmds[$urandom_range(2)]);
            3: begin
                // Read command whose line feed comes too late.
                body.push_back(read_cmds[$urandom_range(2)]);
                repeat ($urandom_range(1, 3)) body.push_back(rand_byte());
            end
            4, 5, 6: begin
                body.push_back(CMD_WRITE);
                repeat (4) body.push_back(rand_byte());
            end
            7: begin
                // Short write that leans on stale bytes in the store.
                body.push_back(CMD_WRITE);
                repeat ($urandom_range(0, 3)) body.push_back(rand_byte());
            end
            8: repeat ($urandom_range(0, 6)) body.push_back(rand_byte());
            default: begin
                // Overlong frame: bytes past the store are dropped.
                repeat ($urandom_range(6, 10)) body.push_back(rand_byte());
            end
        endcase
        body.push_back(LF_CODE);
        foreach (body[i]) begin
            send_rx(row_plain(body[i], rand_word(), rand_word(), rand_word()));
        end
    endtask

    // Receiver stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Predict on each accepted input item; check each accepted reply item.
    always @(posedge aclk) begin : reply_monitor
        stim_row_t   row;
        reply_t      pred;
        reply_byte_t want;
        cycle_count++;
        if (aresetn && s_tvalid && s_tready) begin
            row  = pending_rows.pop_front();
            pred = frame_step(rx_item_t'(s_tdata));
            if (row.literal) begin
                pred = short_reply(row.code, row.refw);
                literal_checked += pred.count;
            end
            for (int k = 0; k < pred.count; k++) begin
                reply_q.push_back(pred.bytes[k]);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            replies_checked++;
            if (reply_q.size() == 0) begin
                $error("Reply item with none expected: tx_byte %h", m_tdata[7:0]);
                error_count++;
            end else begin
                want = reply_q.pop_front();
                if (m_tdata[7:0] !== want.tx) begin
                    $error("tx_byte: expected %h, got %h", want.tx, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_byte: expected %b, got %b", want.last, m_tlast);
                    error_count++;
                end
                if (m_tdata[39:8] !== want.refw) begin
                    $error("reference_angle: expected %h, got %h", want.refw,
                           m_tdata[39:8]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d reply items outstanding",
                 cycle_count, reply_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // Reset, directed table, random frames in three idling phases, then drain.
    initial begin
        directed_rows = '{
            // Line feed alone right after reset: the cleared store gives an error.
            row_literal(LF_CODE, ERR_CODE, 32'h0000_0000),
            row_plain(CMD_ANGLE, 32'h0, 32'h0, 32'h0),
            row_plain(LF_CODE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000),
            row_plain(CMD_PITCH, 32'h0, 32'h0, 32'h0),
            row_plain(LF_CODE, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF),
            row_plain(CMD_ROLL, 32'h0, 32'h0, 32'h0),
            row_plain(LF_CODE, 32'h0000_0000, 32'h0000_0000, 32'h8000_0001),
            // Full write with all-ones payload.
            row_plain(CMD_WRITE, 32'h0, 32'h0, 32'h0),
            row_plain(8'hFF, 32'h0, 32'h0, 32'h0),
            row_plain(8'hFF, 32'h0, 32'h0, 32'h0),
            row_plain(8'hFF, 32'h0, 32'h0, 32'h0),
            row_plain(8'hFF, 32'h0, 32'h0, 32'h0),
            row_literal(LF_CODE, ACK_WRITE, 32'hFFFF_FFFF),
            // Short write accepted through the stale line feed at position 5.
            row_plain(CMD_WRITE, 32'h0, 32'h0, 32'h0),
            row_plain(8'h00, 32'h0, 32'h0, 32'h0),
            row_literal(LF_CODE, ACK_WRITE, 32'hFFFF_0A00),
            // Overlong frame with an unknown command; extra bytes are dropped.
            row_plain(8'hFF, 32'h0, 32'h0, 32'h0),
            row_plain(8'h11, 32'h0, 32'h0, 32'h0),
            row_plain(8'h22, 32'h0, 32'h0, 32'h0),
            row_plain(8'h33, 32'h0, 32'h0, 32'h0),
            row_plain(8'h44, 32'h0, 32'h0, 32'h0),
            row_plain(8'h55, 32'h0, 32'h0, 32'h0),
            row_plain(8'h66, 32'h0, 32'h0, 32'h0),
            row_literal(LF_CODE, ERR_CODE, 32'hFFFF_0A00)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_rx(directed_rows[i]);
        end

        // Random frames; the idling rates swap, then stop, as items go out.
        while (items_sent < $size(directed_rows) + RANDOM_ITEMS) begin
            if (items_sent >= $size(directed_rows) + 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (items_sent >= $size(directed_rows) + RANDOM_ITEMS / 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 13;
            end
            send_random_frame();
        end
        s_tvalid <= 1'b0;

        // Let the monitor take the last item, wait for every expected reply,
        // then watch for strays.
        @(posedge aclk);
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d received bytes closing %0d frames under three stall mixes.",
                 items_sent, frames_sent);
        $display("Compared %0d reply items, %0d of them against typed-in replies.",
                 replies_checked, literal_checked);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
